@@ src/crbrm_pkg.sv @@
// Shared types and constants for the CAN receive buffer with rate meter.
`default_nettype none

package crbrm_pkg;

    localparam int ID_W      = 29;
    localparam int CNT_W     = 4;
    localparam int DATA_W    = 64;
    localparam int BRACKET_W = 16;
    localparam int RATE_W    = BRACKET_W + 1;

    localparam logic [CNT_W-1:0]     MAX_DATA_BYTES = 4'd8;
    localparam logic [BRACKET_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_STATUS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_DROPPED   = 2'd1,
        ERR_OVERSIZE  = 2'd2,
        ERR_RESERVED  = 2'd3
    } t_err;

endpackage

`default_nettype wire

@@ src/crbrm_if.sv @@
// Handshake interfaces for the command words and the result words.
`default_nettype none

interface crbrm_in_if import crbrm_pkg::*; ();
    logic              valid;
    logic              ready;
    t_mode             mode;
    logic [ID_W-1:0]   frame_id;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] payload;
    logic              second_half;

    modport source (output valid, mode, frame_id, byte_count, payload, second_half,
                    input ready);
    modport sink   (input valid, mode, frame_id, byte_count, payload, second_half,
                    output ready);
endinterface

interface crbrm_out_if import crbrm_pkg::*; #(parameter int FILL_W = 5) ();
    logic              valid;
    logic              ready;
    logic              oldest_valid;
    logic [ID_W-1:0]   oldest_id;
    logic [CNT_W-1:0]  oldest_count;
    logic [DATA_W-1:0] oldest_payload;
    logic [FILL_W-1:0] fill_level;
    t_err              error_code;
    logic [RATE_W-1:0] rate_per_second;
    logic [RATE_W-1:0] peak_per_second;

    modport source (output valid, oldest_valid, oldest_id, oldest_count, oldest_payload,
                    fill_level, error_code, rate_per_second, peak_per_second,
                    input ready);
    modport sink   (input valid, oldest_valid, oldest_id, oldest_count, oldest_payload,
                    fill_level, error_code, rate_per_second, peak_per_second,
                    output ready);
endinterface

`default_nettype wire

@@ src/can_rx_buffer_with_rate_meter.sv @@
// Top level: CAN receive frame buffer that drops the oldest frame when full,
// with a half-second bracket message-rate meter.
//
// Each command word on i_in either pushes a frame (mode push), pops the oldest
// frame (mode pop), clears the rate statistics (mode clear) or only asks for
// status; every command word yields exactly one result word on o_out that
// reports the state after the command: the oldest buffered frame (zeros when
// the buffer is empty), the fill level, an error code and the rate figures.
// The block takes one command word per clock cycle unless stalled and answers
// it in the next cycle; the single result register is the only stage, so
// i_in.ready is low only while a result word waits and o_out.ready is low.
// Frames live in three BUFFER_DEPTH-entry memories (identifier, byte count,
// payload) with one write and one registered read per cycle; a push into an
// empty buffer forwards the incoming frame straight into the result register.
// The fill level port is $clog2(BUFFER_DEPTH+1) bits wide, so the output
// interface must be built with FILL_W set to that value. Frame storage is not
// cleared by reset; only frames that are actually buffered are ever reported.
`default_nettype none

module can_rx_buffer_with_rate_meter import crbrm_pkg::*; #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    crbrm_in_if.sink      i_in,
    crbrm_out_if.source   o_out
);

    localparam int PTR_W  = $clog2(BUFFER_DEPTH);
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;

    localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(BUFFER_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(BUFFER_DEPTH - 1);

    // Frame storage, written on a stored push and read for the result word.
    logic [ID_W-1:0]   r_id_mem      [BUFFER_DEPTH];
    logic [CNT_W-1:0]  r_count_mem   [BUFFER_DEPTH];
    logic [DATA_W-1:0] r_payload_mem [BUFFER_DEPTH];

    // Buffer bookkeeping.
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;

    // Rate meter state.
    logic [BRACKET_W-1:0] r_bracket0, n_bracket0;
    logic [BRACKET_W-1:0] r_bracket1, n_bracket1;
    logic                 r_cur_bracket, n_cur_bracket;
    logic [BRACKET_W-1:0] r_peak, n_peak;

    // Result register.
    logic              r_out_valid;
    logic              r_oldest_valid;
    logic [ID_W-1:0]   r_oldest_id;
    logic [CNT_W-1:0]  r_oldest_count;
    logic [DATA_W-1:0] r_oldest_payload;
    logic [FILL_W-1:0] r_fill_level;
    t_err              r_error_code;
    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_peak_rate;

    logic                 accept;
    logic                 oversize;
    logic                 full;
    logic                 store;
    logic                 counted;
    logic                 bypass;
    logic [PTR_W-1:0]     rd_ptr_inc;
    logic [SUM_W-1:0]     wr_sum;
    logic [PTR_W-1:0]     wr_ptr;
    t_err                 n_error;
    logic [BRACKET_W-1:0] cur_count;
    logic [BRACKET_W-1:0] done_count;
    logic [BRACKET_W-1:0] base_count;
    logic [BRACKET_W-1:0] bumped_count;
    logic [BRACKET_W-1:0] finished_count;

    // A new command word can enter whenever the result register is free or
    // is being emptied in the same cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign oversize = i_in.byte_count > MAX_DATA_BYTES;
    assign full     = r_fill == DEPTH_F;
    assign store    = accept && (i_in.mode == MODE_PUSH) && !oversize;
    // Only pushes that did not force out an older frame feed the meter.
    assign counted  = store && !full;

    assign rd_ptr_inc = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    // Write position is the slot just past the newest frame. When the buffer
    // is full that slot is the one the oldest frame occupied.
    assign wr_sum = SUM_W'(r_rd_ptr) + SUM_W'(r_fill);
    always_comb begin
        if (full) begin
            wr_ptr = r_rd_ptr;
        end else if (wr_sum >= DEPTH_S) begin
            wr_ptr = PTR_W'(wr_sum - DEPTH_S);
        end else begin
            wr_ptr = PTR_W'(wr_sum);
        end
    end

    // Pointer, fill level and error code.
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_error  = ERR_NONE;
        if (accept) begin
            unique case (i_in.mode)
                MODE_PUSH: begin
                    if (oversize) begin
                        n_error = ERR_OVERSIZE;
                    end else if (full) begin
                        n_rd_ptr = rd_ptr_inc;
                        n_error  = ERR_DROPPED;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                MODE_POP: begin
                    if (r_fill != '0) begin
                        n_rd_ptr = rd_ptr_inc;
                        n_fill   = r_fill - 1'b1;
                    end
                end
                MODE_CLEAR, MODE_STATUS: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Rate meter. A counted push in the other half of the second closes the
    // current bracket: the peak absorbs it and the new bracket starts at zero.
    assign cur_count    = r_cur_bracket ? r_bracket1 : r_bracket0;
    assign done_count   = cur_count;
    assign base_count   = (i_in.second_half != r_cur_bracket) ? '0 : cur_count;
    assign bumped_count = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;

    always_comb begin
        n_bracket0    = r_bracket0;
        n_bracket1    = r_bracket1;
        n_cur_bracket = r_cur_bracket;
        n_peak        = r_peak;
        if (counted) begin
            if (i_in.second_half != r_cur_bracket && done_count > r_peak) begin
                n_peak = done_count;
            end
            n_cur_bracket = i_in.second_half;
            if (i_in.second_half) begin
                n_bracket1 = bumped_count;
            end else begin
                n_bracket0 = bumped_count;
            end
        end else if (accept && i_in.mode == MODE_CLEAR) begin
            n_bracket0 = '0;
            n_bracket1 = '0;
            n_peak     = '0;
        end
    end

    // The reported rate is the bracket that is not being filled.
    assign finished_count = n_cur_bracket ? n_bracket0 : n_bracket1;

    // A push into an empty buffer makes the incoming frame the oldest one,
    // and it is not in the memory yet when the read happens.
    assign bypass = store && (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_id_mem[wr_ptr]      <= i_in.frame_id;
            r_count_mem[wr_ptr]   <= i_in.byte_count;
            r_payload_mem[wr_ptr] <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr      <= '0;
            r_fill        <= '0;
            r_bracket0    <= '0;
            r_bracket1    <= '0;
            r_cur_bracket <= 1'b0;
            r_peak        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_ptr      <= n_rd_ptr;
            r_fill        <= n_fill;
            r_bracket0    <= n_bracket0;
            r_bracket1    <= n_bracket1;
            r_cur_bracket <= n_cur_bracket;
            r_peak        <= n_peak;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word: the memory read is registered here together with the rest.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fill_level <= n_fill;
            r_error_code <= n_error;
            r_rate       <= {finished_count, 1'b0};
            r_peak_rate  <= {n_peak, 1'b0};
            if (n_fill == '0) begin
                r_oldest_valid   <= 1'b0;
                r_oldest_id      <= '0;
                r_oldest_count   <= '0;
                r_oldest_payload <= '0;
            end else if (bypass) begin
                r_oldest_valid   <= 1'b1;
                r_oldest_id      <= i_in.frame_id;
                r_oldest_count   <= i_in.byte_count;
                r_oldest_payload <= i_in.payload;
            end else begin
                r_oldest_valid   <= 1'b1;
                r_oldest_id      <= r_id_mem[n_rd_ptr];
                r_oldest_count   <= r_count_mem[n_rd_ptr];
                r_oldest_payload <= r_payload_mem[n_rd_ptr];
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.oldest_valid    = r_oldest_valid;
    assign o_out.oldest_id       = r_oldest_id;
    assign o_out.oldest_count    = r_oldest_count;
    assign o_out.oldest_payload  = r_oldest_payload;
    assign o_out.fill_level      = r_fill_level;
    assign o_out.error_code      = r_error_code;
    assign o_out.rate_per_second = r_rate;
    assign o_out.peak_per_second = r_peak_rate;

endmodule

`default_nettype wire
